// ===== rtl/fpr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the frame pacer with rate meter.
// No dependencies; every other file depends on this package.
package fpr_pkg;

  localparam int TIME_BITS_DEF = 48;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 32;
  localparam int COUNT_W   = 21;
  localparam int RATE_W    = 28;
  localparam int PROD_W    = COUNT_W + RATE_W;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FPS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PERIOD = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0]   FPS_RESET     = CFG_W'(60);
  localparam logic [CFG_W-1:0]   PERIOD_RESET  = CFG_W'(16666);
  localparam logic [SUM_W-1:0]   SUM_MAX       = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [RATE_W-1:0]  RATE_MAX      = '1;
  localparam logic [SUM_W-1:0]   ONE_SECOND_US = SUM_W'(1000000);
  localparam logic [RATE_W-1:0]  RATE_SCALE    = RATE_W'(256000000);

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } fpr_rate_req_t;

endpackage

// ===== rtl/fpr_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: timestamp requests, pacing results, register writes.
// Depends on fpr_pkg.
interface fpr_in_if #(parameter int TIME_BITS = fpr_pkg::TIME_BITS_DEF) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_us;
  logic [TIME_BITS-1:0] wake_limit_us;
  modport source (output valid, now_us, wake_limit_us, input ready);
  modport sink (input valid, now_us, wake_limit_us, output ready);
endinterface

interface fpr_out_if #(parameter int TIME_BITS = fpr_pkg::TIME_BITS_DEF) ();
  logic                        valid;
  logic                        ready;
  logic                        frame_due;
  logic                        rate_updated;
  logic [fpr_pkg::RATE_W-1:0]  measured_rate_q8;
  logic [TIME_BITS-1:0]        next_wake_us;
  modport source (output valid, frame_due, rate_updated, measured_rate_q8, next_wake_us,
                  input ready);
  modport sink (input valid, frame_due, rate_updated, measured_rate_q8, next_wake_us,
                output ready);
endinterface

interface fpr_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [fpr_pkg::CFG_IDX_W-1:0] index;
  logic [fpr_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/fpr_rate_unit.sv =====
`timescale 1ns / 1ps
// Rate computation: serial-parallel multiply count * 256e6, then a restoring
// divide by the elapsed sum, one quotient bit per cycle. Depends on fpr_pkg.
module fpr_rate_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  fpr_pkg::fpr_rate_req_t     req,
  output logic                       done,
  output logic [fpr_pkg::RATE_W-1:0] rate
);
  import fpr_pkg::*;

  localparam int STEP_W    = $clog2(PROD_W);
  localparam int MUL_IDX_W = $clog2(RATE_W);

  typedef enum logic [1:0] {RU_IDLE, RU_MUL, RU_DIV} ru_state_t;

  ru_state_t          state;
  logic [STEP_W-1:0]  step;
  logic [COUNT_W-1:0] mcand;
  logic [COUNT_W-1:0] acc;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   divisor;
  logic [SUM_W-1:0]   rem;
  logic [RATE_W-1:0]  quo;
  logic               ovf;

  logic [COUNT_W:0]   mul_sum;
  logic [SUM_W:0]     shifted;
  logic [SUM_W+1:0]   trial;
  logic               qbit;
  logic [RATE_W-1:0]  quo_next;
  logic               ovf_next;

  always_comb begin
    mul_sum  = {1'b0, acc} + (RATE_SCALE[step[MUL_IDX_W-1:0]] ? {1'b0, mcand} : '0);
    shifted  = {rem, prod[PROD_W-1]};
    trial    = {1'b0, shifted} - {2'b00, divisor};
    qbit     = ~trial[SUM_W+1];
    quo_next = {quo[RATE_W-2:0], qbit};
    ovf_next = ovf | quo[RATE_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RU_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == RU_DIV) && (step == STEP_W'(PROD_W - 1));
      unique case (state)
        RU_IDLE: begin
          if (start) begin
            mcand   <= req.count;
            divisor <= req.sum;
            acc     <= '0;
            step    <= '0;
            state   <= RU_MUL;
          end
        end
        RU_MUL: begin
          acc <= mul_sum[COUNT_W:1];
          if (step == STEP_W'(RATE_W - 1)) begin
            prod  <= {mul_sum[COUNT_W:1], mul_sum[0], prod[PROD_W-1:COUNT_W+1]};
            rem   <= '0;
            quo   <= '0;
            ovf   <= 1'b0;
            step  <= '0;
            state <= RU_DIV;
          end else begin
            prod <= {mul_sum[0], prod[PROD_W-1:1]};
            step <= step + STEP_W'(1);
          end
        end
        RU_DIV: begin
          rem  <= qbit ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
          prod <= {prod[PROD_W-2:0], 1'b0};
          quo  <= quo_next;
          ovf  <= ovf_next;
          if (step == STEP_W'(PROD_W - 1)) begin
            rate  <= ovf_next ? RATE_MAX : quo_next;
            state <= RU_IDLE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        default: state <= RU_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/frame_pacer_with_rate_meter.sv =====
`timescale 1ns / 1ps
// Frame pacer with rate meter, top level: bit-serial pacing datapath,
// register file and result register. Depends on fpr_pkg, fpr_if, fpr_rate_unit.
//
//  channel   modport  payload                                       
//  frames    sink     now_us, wake_limit_us                         
//  results   source   frame_due, rate_updated, measured_rate_q8, next_wake_us
//  cfg       sink     index, data (0 target_fps, 1 target_period_us)
//
// A request makes one serial pass over the time word, LSB first, then settles
// and loads the result. A request that closes the one-second window also runs
// the 28 multiply and 49 divide steps in the rate unit, which then hands the
// quotient back.
// Synchronous reset; no clearing pass. A new request is taken while a result
// waits; the block then stalls in result load until the result is taken.
module frame_pacer_with_rate_meter #(
  parameter int TIME_BITS = fpr_pkg::TIME_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  fpr_cfg_if.sink   cfg,
  fpr_in_if.sink    frames,
  fpr_out_if.source results
);
  import fpr_pkg::*;

  localparam int IDX_W = $clog2(TIME_BITS);
  localparam int CW    = IDX_W + 1;

  typedef enum logic [2:0] {ST_IDLE, ST_SHIFT, ST_SETTLE, ST_RATE, ST_EMIT} state_t;

  state_t               state;
  logic [IDX_W-1:0]     bit_idx;
  logic [CFG_W-1:0]     target_period;
  logic [TIME_BITS-1:0] last_frame_start;
  logic [SUM_W-1:0]     elapsed_sum;
  logic [COUNT_W-1:0]   frames_in_window;
  logic [RATE_W-1:0]    rate_value;

  logic [TIME_BITS-1:0] now_sr;
  logic [TIME_BITS-1:0] lim_sr;
  logic [TIME_BITS-1:0] wn_sr;
  logic [TIME_BITS-1:0] wl_sr;
  logic [SUM_W-1:0]     sum_new;
  logic                 sub_borrow;
  logic                 sum_carry;
  logic                 sum_ovf;
  logic                 wn_carry;
  logic                 wl_carry;
  logic                 ge_flag;
  logic                 ltn_flag;
  logic                 ltl_flag;
  logic                 due_r;
  logic                 upd_r;
  logic [TIME_BITS-1:0] wake_r;

  logic                 out_valid;
  logic                 out_due;
  logic                 out_upd;
  logic [RATE_W-1:0]    out_rate;
  logic [TIME_BITS-1:0] out_wake;

  // serial datapath bits
  logic [CW-1:0]        wide_idx;
  logic                 per_lo, sum_lo;
  logic                 a, b, p, s, l;
  logic                 e, borrow_next, r, carry_next;
  logic                 wn, wn_carry_next, wl, wl_carry_next;

  // settle
  logic [SUM_W-1:0]     sum_cand;
  logic [COUNT_W-1:0]   count_cand;
  logic                 rate_go;
  logic [TIME_BITS-1:0] wend;
  logic                 lt;
  logic [TIME_BITS-1:0] wake;
  logic                 emit_load;

  fpr_rate_req_t        rate_req;
  logic                 rate_start;
  logic                 rate_done;
  logic [RATE_W-1:0]    rate_q;

  always_comb begin
    wide_idx = CW'(bit_idx);
    per_lo   = wide_idx < CW'(CFG_W);
    sum_lo   = wide_idx < CW'(SUM_W);
    a = now_sr[0];
    b = last_frame_start[0];
    p = per_lo & target_period[0];
    s = sum_lo & elapsed_sum[0];
    l = lim_sr[0];

    e             = a ^ b ^ sub_borrow;
    borrow_next   = (~a & b) | (~(a ^ b) & sub_borrow);
    r             = s ^ e ^ sum_carry;
    carry_next    = (s & e) | (s & sum_carry) | (e & sum_carry);
    wn            = a ^ p ^ wn_carry;
    wn_carry_next = (a & p) | (a & wn_carry) | (p & wn_carry);
    wl            = b ^ p ^ wl_carry;
    wl_carry_next = (b & p) | (b & wl_carry) | (p & wl_carry);

    sum_cand   = (sum_ovf | sum_carry) ? SUM_MAX : sum_new;
    count_cand = (frames_in_window == COUNT_MAX) ? frames_in_window
                                                 : frames_in_window + COUNT_W'(1);
    rate_go    = ge_flag && (sum_cand >= ONE_SECOND_US);
    wend       = ge_flag ? wn_sr : wl_sr;
    lt         = ge_flag ? ltn_flag : ltl_flag;
    wake       = lt ? wend : lim_sr;
    emit_load  = (state == ST_EMIT) && (!out_valid || results.ready);

    rate_req.count = count_cand;
    rate_req.sum   = sum_cand;
    rate_start     = (state == ST_SETTLE) && rate_go;
  end

  fpr_rate_unit u_rate (
    .clk   (clk),
    .rst   (rst),
    .start (rate_start),
    .req   (rate_req),
    .done  (rate_done),
    .rate  (rate_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      target_period    <= PERIOD_RESET;
      last_frame_start <= '0;
      elapsed_sum      <= '0;
      frames_in_window <= '0;
      rate_value       <= {FPS_RESET, 8'h00};
    end else begin
      out_valid <= emit_load || (out_valid && !results.ready);
      unique case (state)
        ST_IDLE: begin
          if (frames.valid) begin
            now_sr     <= frames.now_us;
            lim_sr     <= frames.wake_limit_us;
            bit_idx    <= '0;
            sub_borrow <= 1'b0;
            sum_carry  <= 1'b0;
            sum_ovf    <= 1'b0;
            wn_carry   <= 1'b0;
            wl_carry   <= 1'b0;
            ge_flag    <= 1'b1;
            ltn_flag   <= 1'b0;
            ltl_flag   <= 1'b0;
            state      <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          now_sr           <= {a, now_sr[TIME_BITS-1:1]};
          lim_sr           <= {l, lim_sr[TIME_BITS-1:1]};
          last_frame_start <= {b, last_frame_start[TIME_BITS-1:1]};
          wn_sr            <= {wn, wn_sr[TIME_BITS-1:1]};
          wl_sr            <= {wl, wl_sr[TIME_BITS-1:1]};
          if (per_lo) begin
            target_period <= {target_period[0], target_period[CFG_W-1:1]};
          end
          if (sum_lo) begin
            elapsed_sum <= {elapsed_sum[0], elapsed_sum[SUM_W-1:1]};
            sum_new     <= {r, sum_new[SUM_W-1:1]};
          end else begin
            sum_ovf <= sum_ovf | r;
          end
          sub_borrow <= borrow_next;
          sum_carry  <= carry_next;
          wn_carry   <= wn_carry_next;
          wl_carry   <= wl_carry_next;
          if (e != p) begin
            ge_flag <= e;
          end
          if (wn != l) begin
            ltn_flag <= l;
          end
          if (wl != l) begin
            ltl_flag <= l;
          end
          if (bit_idx == IDX_W'(TIME_BITS - 1)) begin
            state <= ST_SETTLE;
          end else begin
            bit_idx <= bit_idx + IDX_W'(1);
          end
        end
        ST_SETTLE: begin
          due_r  <= ge_flag;
          upd_r  <= rate_go;
          wake_r <= wake;
          if (ge_flag) begin
            last_frame_start <= now_sr;
          end
          if (rate_go) begin
            elapsed_sum      <= '0;
            frames_in_window <= '0;
            state            <= ST_RATE;
          end else begin
            if (ge_flag) begin
              elapsed_sum      <= sum_cand;
              frames_in_window <= count_cand;
            end
            state <= ST_EMIT;
          end
        end
        ST_RATE: begin
          if (rate_done) begin
            rate_value <= rate_q;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_due   <= due_r;
            out_upd   <= upd_r;
            out_rate  <= rate_value;
            out_wake  <= wake_r;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg.valid) begin
        // target_fps only seeds the reported rate
        unique case (cfg.index)
          REG_TARGET_FPS: begin
            rate_value <= {cfg.data, 8'h00};
          end
          REG_TARGET_PERIOD: begin
            target_period <= cfg.data;
          end
          default: ;
        endcase
      end
    end
  end

  assign frames.ready             = (state == ST_IDLE);
  assign cfg.ready                = 1'b1;
  assign results.valid            = out_valid;
  assign results.frame_due        = out_due;
  assign results.rate_updated     = out_upd;
  assign results.measured_rate_q8 = out_rate;
  assign results.next_wake_us     = out_wake;

endmodule

// ===== dv/frame_pacer_with_rate_meter_test.sv =====
`timescale 1ns / 1ps
// Self-checking test for frame_pacer_with_rate_meter: a directed table, then phased
// random timestamp requests, each result checked against the table's expected
// values or a pacing predictor. Depends on fpr_pkg, fpr_if and the RTL top level.
module frame_pacer_with_rate_meter_test;
  import fpr_pkg::*;

  localparam int TIME_W       = TIME_BITS_DEF;
  localparam int CLK_HALF     = 4;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_AT      = 350;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 215;
  localparam int PHASES       = 6;
  localparam int PHASE_FPS    [PHASES] = '{60, 1000000, 1, 144, 0, 30};
  localparam int PHASE_PERIOD [PHASES] = '{16666, 1, 1000000, 6944, 0, 33333};

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam logic [TIME_W-1:0]    NO_LIMIT    = '1;
  localparam logic [CFG_W-1:0]     CFG_ALL     = '1;

  typedef struct packed {
    logic              frame_due;
    logic              rate_updated;
    logic [RATE_W-1:0] rate_q8;
    logic [TIME_W-1:0] next_wake;
  } pacing_t;

  typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]   data;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  wake;
    bit                 fixed;
    pacing_t            want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpr_cfg_if                      cfg_if ();
  fpr_in_if  #(.TIME_BITS(TIME_W)) frames_if ();
  fpr_out_if #(.TIME_BITS(TIME_W)) results_if ();

  frame_pacer_with_rate_meter #(.TIME_BITS(TIME_W)) u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .frames  (frames_if),
    .results (results_if)
  );

  always #(CLK_HALF) clk = ~clk;

  // predictor state
  logic [CFG_W-1:0]   cfg_fps;
  logic [CFG_W-1:0]   cfg_period;
  logic [TIME_W-1:0]  frame_start;
  logic [SUM_W-1:0]   window_sum;
  logic [COUNT_W-1:0] window_frames;
  logic [RATE_W-1:0]  rate_now;

  pacing_t pacing_q [$];
  row_t    steps [$];
  int      mismatches   = 0;
  int      results_seen = 0;
  int      quiet_cycles = 0;
  bit      bursts_on    = 1'b1;

  function automatic void pacer_write(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
    case (index)
      REG_TARGET_FPS: begin
        cfg_fps  = data;
        rate_now = {data, 8'h00};
      end
      REG_TARGET_PERIOD: cfg_period = data;
      default: ;
    endcase
  endfunction

  function automatic pacing_t pace_frame(logic [TIME_W-1:0] now, logic [TIME_W-1:0] wake);
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] window_end;
    logic [63:0]       quotient;
    pacing_t           r;
    elapsed        = now - frame_start;
    r.frame_due    = (elapsed >= TIME_W'(cfg_period));
    r.rate_updated = 1'b0;
    if (r.frame_due) begin
      frame_start = now;
      if (64'(elapsed) >= 64'(SUM_MAX) - 64'(window_sum)) begin
        window_sum = SUM_MAX;
      end else begin
        window_sum = window_sum + SUM_W'(elapsed);
      end
      if (window_frames != COUNT_MAX) window_frames = window_frames + 1'b1;
      if (window_sum >= ONE_SECOND_US) begin
        quotient       = (64'(RATE_SCALE) * 64'(window_frames)) / 64'(window_sum);
        rate_now       = (quotient > 64'(RATE_MAX)) ? RATE_MAX : RATE_W'(quotient);
        window_sum     = '0;
        window_frames  = '0;
        r.rate_updated = 1'b1;
      end
    end
    window_end = frame_start + TIME_W'(cfg_period);
    r.rate_q8   = rate_now;
    r.next_wake = (window_end < wake) ? window_end : wake;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[TIME_W-1:0];
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
    row_t r;
    r = '{kind: ROW_WRITE, index: index, data: data, now: '0, wake: '0, fixed: 1'b0,
          want: '0};
    steps.push_back(r);
  endfunction

  function automatic void add_frame(logic [TIME_W-1:0] now, logic [TIME_W-1:0] wake,
                                    bit fixed = 1'b0, pacing_t want = '0);
    row_t r;
    r = '{kind: ROW_FRAME, index: '0, data: '0, now: now, wake: wake, fixed: fixed,
          want: want};
    steps.push_back(r);
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  // entered and left at a falling edge
  task automatic send_request(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] wake,
                              input bit fixed, input pacing_t want);
    pacing_t predicted;
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      frames_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    frames_if.valid         <= 1'b1;
    frames_if.now_us        <= now;
    frames_if.wake_limit_us <= wake;
    do @(posedge clk); while (!frames_if.ready);
    predicted = pace_frame(now, wake);
    pacing_q.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    frames_if.valid <= 1'b0;
    while (pacing_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    pacer_write(index, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int unsigned       per;
    int unsigned       mode;
    int unsigned       pick;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] wake;
    frames_if.valid         = 1'b0;
    frames_if.now_us        = '0;
    frames_if.wake_limit_us = '0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = '0;
    cfg_if.data             = '0;
    cfg_fps       = FPS_RESET;
    cfg_period    = PERIOD_RESET;
    frame_start   = '0;
    window_sum    = '0;
    window_frames = '0;
    rate_now      = {FPS_RESET, 8'h00};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // after reset: not due until the reset period has passed
    add_frame(48'd0,       NO_LIMIT, 1'b1, '{1'b0, 1'b0, RATE_W'(15360), TIME_W'(16666)});
    add_frame(48'd16665,   NO_LIMIT, 1'b1, '{1'b0, 1'b0, RATE_W'(15360), TIME_W'(16666)});
    add_frame(48'd16666,   48'd0,    1'b1, '{1'b1, 1'b0, RATE_W'(15360), TIME_W'(0)});
    add_frame(48'd1016666, NO_LIMIT, 1'b1, '{1'b1, 1'b1, RATE_W'(503), TIME_W'(1033332)});
    // jump to the largest timestamp: saturated sum, rate floors to zero, wake time wraps
    add_frame(NO_LIMIT,    NO_LIMIT, 1'b1, '{1'b1, 1'b1, RATE_W'(0), TIME_W'(16665)});
    add_frame(48'd16664,   NO_LIMIT, 1'b1, '{1'b0, 1'b0, RATE_W'(0), TIME_W'(16665)});
    add_frame(48'd16665,   NO_LIMIT, 1'b1, '{1'b1, 1'b0, RATE_W'(0), TIME_W'(33331)});
    // zero period: every request is due
    add_write(REG_TARGET_FPS, CFG_W'(1000000));
    add_write(REG_TARGET_PERIOD, CFG_W'(0));
    add_frame(48'd16665, NO_LIMIT, 1'b1, '{1'b1, 1'b0, RATE_W'(256000000), TIME_W'(16665)});
    // unknown indexes are ignored
    add_write(REG_SPARE_A, CFG_W'(5));
    add_write(REG_SPARE_B, CFG_ALL);
    add_frame(48'd16665, 48'd0, 1'b1, '{1'b1, 1'b0, RATE_W'(256000000), TIME_W'(0)});
    add_write(REG_TARGET_FPS, CFG_W'(0));
    add_frame(48'd16665, NO_LIMIT, 1'b1, '{1'b1, 1'b0, RATE_W'(0), TIME_W'(16665)});
    add_write(REG_TARGET_FPS, CFG_ALL);
    add_write(REG_TARGET_PERIOD, CFG_ALL);
    add_frame(48'd1065240, NO_LIMIT);
    add_frame(48'd2113814, NO_LIMIT);
    add_frame(48'd2113815, 48'h5555_AAAA_5555);
    add_write(REG_TARGET_FPS, CFG_W'(1));
    add_write(REG_TARGET_PERIOD, CFG_W'(1000000));
    add_frame(48'd3113815, NO_LIMIT);
    add_frame(48'd4113814, 48'hAAAA_5555_AAAA);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(steps[i].index, steps[i].data);
      end else begin
        send_request(steps[i].now, steps[i].wake, steps[i].fixed, steps[i].want);
      end
    end

    stamp = frame_start;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(REG_TARGET_FPS, CFG_W'(PHASE_FPS[p]));
      write_reg(REG_TARGET_PERIOD, CFG_W'(PHASE_PERIOD[p]));
      if (p == 3) write_reg(REG_SPARE_B, CFG_W'($urandom()));
      bursts_on = (p != PHASES - 1);
      per = cfg_period;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = $urandom_range(0, 99);
        if (mode < 60)
          stamp = stamp + TIME_W'(per / 2 + $urandom_range(0, per + per / 2));
        else if (mode < 80)
          stamp = stamp + TIME_W'($urandom_range(0, 300000));
        else if (mode < 90)
          stamp = stamp + TIME_W'(per == 0 ? 0 : $urandom_range(0, per - 1));
        else if (mode < 95)
          stamp = rand_time();
        else
          stamp = frame_start + TIME_W'(per) - TIME_W'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 30)
          wake = NO_LIMIT;
        else if (pick < 60)
          wake = stamp + TIME_W'($urandom_range(0, 2 * per + 100));
        else if (pick < 80)
          wake = rand_time();
        else if (pick < 85)
          wake = '0;
        else
          wake = stamp + TIME_W'(per) + TIME_W'($urandom_range(0, 2)) - 1'b1;
        send_request(stamp, wake, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off that backs up the input
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 1'b0;
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        stall_left = HOLD_CYCLES;
        held       = 1'b1;
      end else if (stall_left == 0 && bursts_on && $urandom_range(0, 24) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (rst || stall_left > 0) begin
        results_if.ready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pacing_t want;
    if (!rst && results_if.valid === 1'b1 && results_if.ready) begin
      results_seen++;
      if (pacing_q.size() == 0) begin
        report_mismatch("result with no request pending", 64'(results_if.next_wake_us), '0);
      end else begin
        want = pacing_q.pop_front();
        if (results_if.frame_due !== want.frame_due)
          report_mismatch("frame_due", 64'(results_if.frame_due), 64'(want.frame_due));
        if (results_if.rate_updated !== want.rate_updated)
          report_mismatch("rate_updated", 64'(results_if.rate_updated),
                          64'(want.rate_updated));
        if (results_if.measured_rate_q8 !== want.rate_q8)
          report_mismatch("measured_rate_q8", 64'(results_if.measured_rate_q8),
                          64'(want.rate_q8));
        if (results_if.next_wake_us !== want.next_wake)
          report_mismatch("next_wake_us", 64'(results_if.next_wake_us), 64'(want.next_wake));
      end
    end
  end

  always @(posedge clk) begin
    if ((frames_if.valid && frames_if.ready) || (results_if.valid && results_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
